FILE: design/can_lfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_lfr_pkg
// Shared sizes, codes and the command format between the front and back end
// of the long frame reassembler.
// ----------------------------------------------------------------------------
package can_lfr_pkg;

	localparam int NUM_ENTRIES = 4;
	localparam int ENTRY_BYTES = 56;
	localparam int SEG_BYTES   = 7;
	localparam int MAX_SEG     = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int ID_W    = 29;
	localparam int ENT_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int FILL_W  = $clog2(ENTRY_BYTES + 1);
	localparam int OFF_W   = $clog2(MAX_SEG * SEG_BYTES);
	localparam int CNT_W   = $clog2(SEG_BYTES + 1);
	localparam int MEM_DEPTH = NUM_ENTRIES * ENTRY_BYTES;
	localparam int ADDR_W  = $clog2(MEM_DEPTH);
	localparam int OIDX_W  = 6;

	localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

	localparam logic [1:0] POS_SINGLE = 2'd0;
	localparam logic [1:0] POS_BEGIN  = 2'd1;
	localparam logic [1:0] POS_MIDDLE = 2'd2;
	localparam logic [1:0] POS_END    = 2'd3;

	localparam logic [1:0] ST_BYTE     = 2'd0;
	localparam logic [1:0] ST_NO_FREE  = 2'd1;
	localparam logic [1:0] ST_NO_ENTRY = 2'd2;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_EMIT,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic [ENT_W-1:0]            entry;
		logic [ID_W-1:0]             id;
		logic [OFF_W-1:0]            offset;
		logic [CNT_W-1:0]            count;
		logic [SEG_BYTES-1:0][7:0]   data;
		logic [FILL_W-1:0]           len;
		logic [1:0]                  status;
	} cmd_t;

endpackage

FILE: design/can_lfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_lfr_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module can_lfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/can_lfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_lfr_queue
// Short command queue between the front and back end.
// ----------------------------------------------------------------------------
module can_lfr_queue
	import can_lfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign full    = (level_q == LVL_W'(QUEUE_DEPTH));
	assign empty   = (level_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

FILE: design/can_lfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_lfr_front
// Accepts frames, frees timed-out entries, looks up the entry and queues a
// command for the back end. Holds the entry table and the timeout register.
// ----------------------------------------------------------------------------
module can_lfr_front
	import can_lfr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ID_W-1:0]           frame_id,
	input  logic [1:0]                position,
	input  logic [3:0]                seg_num,
	input  logic [3:0]                byte_count,
	input  logic [SEG_BYTES-1:0][7:0] data,
	input  logic [31:0]               now,
	input  logic                      cfg_we,
	input  logic [31:0]               cfg_wdata,
	output logic                      push,
	output cmd_t                      push_cmd,
	input  logic                      full
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_SWEEP,
		F_LOOKUP
	} fstate_t;

	fstate_t                   state_q;
	logic [31:0]               timeout_q;
	logic [ID_W-1:0]           key_q   [NUM_ENTRIES];
	logic [FILL_W-1:0]         fill_q  [NUM_ENTRIES];
	logic [31:0]               stamp_q [NUM_ENTRIES];

	logic [ID_W-1:0]           id_q;
	logic [1:0]                pos_q;
	logic [3:0]                seg_q;
	logic [3:0]                cnt_q;
	logic [SEG_BYTES-1:0][7:0] data_q;
	logic [31:0]               now_q;

	logic                      hit_found;
	logic [ENT_W-1:0]          hit_idx;
	logic                      free_found;
	logic [ENT_W-1:0]          free_idx;
	logic                      sel_found;
	logic [ENT_W-1:0]          sel_idx;
	logic [CNT_W-1:0]          end_n;
	logic [CNT_W-1:0]          add_n;
	logic [FILL_W:0]           fill_sum;
	logic [FILL_W-1:0]         fill_new;
	logic [OFF_W-1:0]          seg_off;

	assign busy = (state_q != F_IDLE);

	always_comb begin
		hit_found  = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
			if (fill_q[e] != '0 && key_q[e] == id_q) begin
				hit_found = 1'b1;
				hit_idx   = ENT_W'(e);
			end
			if (fill_q[e] == '0) begin
				free_found = 1'b1;
				free_idx   = ENT_W'(e);
			end
		end
	end

	always_comb begin
		if (pos_q == POS_BEGIN) begin
			sel_found = hit_found || free_found;
			sel_idx   = hit_found ? hit_idx : free_idx;
		end else begin
			sel_found = hit_found;
			sel_idx   = hit_idx;
		end
		if (cnt_q == 4'd0) begin
			end_n = '0;
		end else if (cnt_q - 4'd1 > 4'(SEG_BYTES)) begin
			end_n = CNT_W'(SEG_BYTES);
		end else begin
			end_n = CNT_W'(cnt_q - 4'd1);
		end
		add_n    = (pos_q == POS_END) ? end_n : CNT_W'(SEG_BYTES);
		fill_sum = (FILL_W + 1)'(fill_q[sel_idx]) + (FILL_W + 1)'(add_n);
		fill_new = (fill_sum > (FILL_W + 1)'(ENTRY_BYTES)) ?
			FILL_W'(ENTRY_BYTES) : fill_sum[FILL_W-1:0];
		seg_off  = OFF_W'(seg_q) * OFF_W'(SEG_BYTES);
	end

	always_comb begin
		push_cmd        = '0;
		push_cmd.id     = id_q;
		push_cmd.entry  = sel_idx;
		push_cmd.data   = data_q;
		push_cmd.len    = fill_new;
		push = (state_q == F_LOOKUP) && !full;
		if (!sel_found) begin
			push_cmd.kind   = CMD_ERROR;
			push_cmd.status = (pos_q == POS_BEGIN) ? ST_NO_FREE : ST_NO_ENTRY;
		end else begin
			push_cmd.status = ST_BYTE;
			case (pos_q)
				POS_BEGIN: begin
					push_cmd.kind   = CMD_WRITE;
					push_cmd.offset = '0;
					push_cmd.count  = CNT_W'(SEG_BYTES);
				end
				POS_END: begin
					push_cmd.kind   = CMD_EMIT;
					push_cmd.offset = seg_off;
					push_cmd.count  = end_n;
				end
				default: begin
					push_cmd.kind   = CMD_WRITE;
					push_cmd.offset = seg_off;
					push_cmd.count  = CNT_W'(SEG_BYTES);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			id_q   <= frame_id;
			pos_q  <= position;
			seg_q  <= seg_num;
			cnt_q  <= byte_count;
			data_q <= data;
			now_q  <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			timeout_q <= TIMEOUT_RESET;
			for (int e = 0; e < NUM_ENTRIES; e++) begin
				key_q[e]   <= '0;
				fill_q[e]  <= '0;
				stamp_q[e] <= '0;
			end
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			case (state_q)
				F_IDLE: begin
					if (start && position != POS_SINGLE) begin
						state_q <= F_SWEEP;
					end
				end
				F_SWEEP: begin
					for (int e = 0; e < NUM_ENTRIES; e++) begin
						if (fill_q[e] != '0 && (now_q - stamp_q[e]) > timeout_q) begin
							key_q[e]  <= '0;
							fill_q[e] <= '0;
						end
					end
					state_q <= F_LOOKUP;
				end
				F_LOOKUP: begin
					if (!full) begin
						state_q <= F_IDLE;
						if (sel_found) begin
							stamp_q[sel_idx] <= now_q;
							case (pos_q)
								POS_BEGIN: begin
									key_q[sel_idx]  <= id_q;
									fill_q[sel_idx] <= FILL_W'(SEG_BYTES);
								end
								POS_END: begin
									key_q[sel_idx]  <= '0;
									fill_q[sel_idx] <= '0;
								end
								default: begin
									fill_q[sel_idx] <= fill_new;
								end
							endcase
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: design/can_lfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_lfr_back
// Executes queued commands: writes frame bytes into the payload store and
// streams a finished payload, or an error, out one item per cycle.
// ----------------------------------------------------------------------------
module can_lfr_back
	import can_lfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              pop_cmd,
	input  logic              empty,
	output logic              pop,
	output logic              result_valid,
	output logic [ID_W-1:0]   out_id,
	output logic [7:0]        out_byte,
	output logic [OIDX_W-1:0] out_index,
	output logic              out_last,
	output logic [1:0]        status
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_WRITE,
		B_EMIT
	} bstate_t;

	bstate_t                state_q;
	cmd_t                   cmd_q;
	logic [CNT_W-1:0]       wr_cnt_q;
	logic [FILL_W-1:0]      rd_cnt_q;
	logic [MEM_DEPTH-1:0]   written_q;

	logic                   valid_s1;
	logic [ID_W-1:0]        id_s1;
	logic [OIDX_W-1:0]      index_s1;
	logic                   last_s1;
	logic [1:0]             status_s1;
	logic                   use_ram_s1;

	logic [OFF_W:0]         wr_off;
	logic [ADDR_W:0]        base;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [7:0]             ram_rdata;
	logic                   rd_last;

	assign pop     = (state_q == B_IDLE) && !empty;
	assign base    = (ADDR_W + 1)'(cmd_q.entry) * (ADDR_W + 1)'(ENTRY_BYTES);
	assign wr_off  = (OFF_W + 1)'(cmd_q.offset) + (OFF_W + 1)'(wr_cnt_q);
	assign ram_we  = (state_q == B_WRITE) && (wr_cnt_q < cmd_q.count) &&
		(wr_off < (OFF_W + 1)'(ENTRY_BYTES));
	assign ram_waddr = ADDR_W'(base + (ADDR_W + 1)'(wr_off));
	assign ram_raddr = ADDR_W'(base + (ADDR_W + 1)'(rd_cnt_q));
	assign rd_last   = (rd_cnt_q + 1'b1 == cmd_q.len);

	can_lfr_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd_q.data[wr_cnt_q]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_cmd;
		end
		id_s1 <= (pop) ? pop_cmd.id : cmd_q.id;
		if (pop) begin
			index_s1   <= '0;
			last_s1    <= 1'b1;
			status_s1  <= pop_cmd.status;
			use_ram_s1 <= 1'b0;
		end else begin
			index_s1   <= OIDX_W'(rd_cnt_q);
			last_s1    <= rd_last;
			status_s1  <= ST_BYTE;
			use_ram_s1 <= written_q[ram_raddr];
		end
		out_id    <= id_s1;
		out_byte  <= use_ram_s1 ? ram_rdata : 8'd0;
		out_index <= index_s1;
		out_last  <= last_s1;
		status    <= status_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			wr_cnt_q     <= '0;
			rd_cnt_q     <= '0;
			written_q    <= '0;
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= valid_s1;
			valid_s1     <= 1'b0;
			if (ram_we) begin
				written_q[ram_waddr] <= 1'b1;
			end
			case (state_q)
				B_IDLE: begin
					wr_cnt_q <= '0;
					rd_cnt_q <= '0;
					if (pop) begin
						if (pop_cmd.kind == CMD_ERROR) begin
							valid_s1 <= 1'b1;
						end else begin
							state_q <= B_WRITE;
						end
					end
				end
				B_WRITE: begin
					if (wr_cnt_q < cmd_q.count) begin
						wr_cnt_q <= wr_cnt_q + 1'b1;
					end else if (cmd_q.kind == CMD_EMIT) begin
						state_q <= B_EMIT;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_EMIT: begin
					valid_s1 <= 1'b1;
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_last) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

FILE: design/can_lfr_front_back_note.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_long_frame_reassembler_core
// Top level of the segmented CAN frame reassembler.
// ----------------------------------------------------------------------------
// After a frame is taken, busy is high through the sweep and lookup states;
// lookup holds while the command queue is full. The back end pops a command,
// writes its stored bytes one at a time, then streams a payload one byte per
// cycle through the RAM read, s1 and output registers. The byte-wide store
// port limits the frame rate; the receiver cannot stall the results. Reset
// clears the entry table; every store byte is marked unwritten and reads zero.
module can_long_frame_reassembler_core
	import can_lfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ID_W-1:0]   frame_id,
	input  logic [1:0]        position,
	input  logic [3:0]        seg_num,
	input  logic [3:0]        byte_count,
	input  logic [7:0]        data0,
	input  logic [7:0]        data1,
	input  logic [7:0]        data2,
	input  logic [7:0]        data3,
	input  logic [7:0]        data4,
	input  logic [7:0]        data5,
	input  logic [7:0]        data6,
	input  logic [31:0]       now,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	output logic              result_valid,
	output logic [ID_W-1:0]   out_id,
	output logic [7:0]        out_byte,
	output logic [OIDX_W-1:0] out_index,
	output logic              out_last,
	output logic [1:0]        status
);

	logic [SEG_BYTES-1:0][7:0] data;
	logic                      push;
	cmd_t                      push_cmd;
	logic                      full;
	logic                      pop;
	cmd_t                      pop_cmd;
	logic                      empty;

	assign data = {data6, data5, data4, data3, data2, data1, data0};

	can_lfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.frame_id   (frame_id),
		.position   (position),
		.seg_num    (seg_num),
		.byte_count (byte_count),
		.data       (data),
		.now        (now),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full)
	);

	can_lfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	can_lfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_cmd      (pop_cmd),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.out_id       (out_id),
		.out_byte     (out_byte),
		.out_index    (out_index),
		.out_last     (out_last),
		.status       (status)
	);

endmodule
